FILE: rtl/ftg_pkg.sv
// shared types and constants for the flow tuple generator
package ftg_pkg;

  localparam int EXCL_DEPTH_DEF = 16;
  localparam int ADDR_W = 32;
  localparam int PORT_W = 16;
  localparam int PROTO_W = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    OP_RESTART = 2'd0,
    OP_ADD_SRC = 2'd1,
    OP_ADD_DST = 2'd2,
    OP_STEP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_FINISHED = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_FIRST   = 3'd0,
    REG_SRC_LAST    = 3'd1,
    REG_DST_FIRST   = 3'd2,
    REG_DST_LAST    = 3'd3,
    REG_SPORT_RANGE = 3'd4,
    REG_DPORT_RANGE = 3'd5,
    REG_PROTOCOL    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } excl_wr_t;

  typedef struct packed {
    logic full;
    logic hit;
  } excl_stat_t;

endpackage

FILE: rtl/ftg_excl_table.sv
// address exclusion table with fill count and parallel match
module ftg_excl_table #(
  parameter int EXCL_DEPTH = ftg_pkg::EXCL_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ftg_pkg::excl_wr_t         wr,
  input  logic [ftg_pkg::ADDR_W-1:0] lookup_addr,
  output ftg_pkg::excl_stat_t       stat
);

  localparam int CNT_W = $clog2(EXCL_DEPTH + 1);
  localparam int IDX_W = (EXCL_DEPTH > 1) ? $clog2(EXCL_DEPTH) : 1;

  logic [ftg_pkg::ADDR_W-1:0] entries [EXCL_DEPTH];
  logic [CNT_W-1:0]           count;
  logic                       full;
  logic                       hit;

  assign full = (count == CNT_W'(EXCL_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (wr.en && !full) begin
      count <= count + CNT_W'(1);
    end
  end

  // entries above the count are never compared, so no reset is needed
  always_ff @(posedge clk) begin
    if (wr.en && !full) begin
      entries[count[IDX_W-1:0]] <= wr.addr;
    end
  end

  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < EXCL_DEPTH; i++) begin
      if ((CNT_W'(i) < count) && (entries[i] == lookup_addr)) begin
        hit = 1'b1;
      end
    end
  end

  assign stat.full = full;
  assign stat.hit  = hit;

endmodule

FILE: rtl/flow_tuple_generator_core.sv
// flow tuple generator: enumerates ipv4 flow tuples with address exclusion
//
// Input channel (in_valid/in_ready, op, entry_addr) carries commands: restart,
// add a source or destination exclusion, or step the tuple counters. Every
// accepted command gives exactly one result transaction on the output channel
// (out_valid/out_ready, emitted, src_addr, dst_addr, src_port, dst_port,
// proto_out, last, status). The configuration channel (cfg_valid/cfg_ready,
// cfg_index, cfg_data) writes the range and protocol registers; it is always
// ready and should only be written while no command is in flight.
// A command is captured in an input register and resolved combinationally into
// the result register; while the receiver takes every result, one command is
// accepted every cycle. The exclusion match over EXCL_DEPTH entries per table
// is combinational and sets the critical path.
// When the receiver stalls, the result is held and one more command may sit in
// the input register; after that in_ready drops until the result is taken.
// Reset clears the config, sequence and valid registers, empties both exclusion
// tables and marks the sequence finished, so steps report finished until the first restart.
module flow_tuple_generator_core #(
  parameter int EXCL_DEPTH = ftg_pkg::EXCL_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    op,
  input  logic [ftg_pkg::ADDR_W-1:0]    entry_addr,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          emitted,
  output logic [ftg_pkg::ADDR_W-1:0]    src_addr,
  output logic [ftg_pkg::ADDR_W-1:0]    dst_addr,
  output logic [ftg_pkg::PORT_W-1:0]    src_port,
  output logic [ftg_pkg::PORT_W-1:0]    dst_port,
  output logic [ftg_pkg::PROTO_W-1:0]   proto_out,
  output logic                          last,
  output logic [1:0]                    status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ftg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ftg_pkg::CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic [ftg_pkg::ADDR_W-1:0]     src_first;
  logic [ftg_pkg::ADDR_W-1:0]     src_last;
  logic [ftg_pkg::ADDR_W-1:0]     dst_first;
  logic [ftg_pkg::ADDR_W-1:0]     dst_last;
  logic [ftg_pkg::CFG_DATA_W-1:0] sport_range;
  logic [ftg_pkg::CFG_DATA_W-1:0] dport_range;
  logic [ftg_pkg::PROTO_W-1:0]    protocol;

  // sequence state
  logic [ftg_pkg::ADDR_W-1:0] src_cur;
  logic [ftg_pkg::ADDR_W-1:0] dst_cur;
  logic [ftg_pkg::PORT_W-1:0] sport_cur;
  logic [ftg_pkg::PORT_W-1:0] dport_cur;
  logic                       finished;
  logic [ftg_pkg::ADDR_W-1:0] src_cur_next;
  logic [ftg_pkg::ADDR_W-1:0] dst_cur_next;
  logic [ftg_pkg::PORT_W-1:0] sport_cur_next;
  logic [ftg_pkg::PORT_W-1:0] dport_cur_next;
  logic                       finished_next;

  // input register
  logic                       s1_valid;
  ftg_pkg::op_t               s1_op;
  logic [ftg_pkg::ADDR_W-1:0] s1_addr;

  logic proc;

  logic [ftg_pkg::PORT_W-1:0] sp_first;
  logic [ftg_pkg::PORT_W-1:0] sp_last;
  logic [ftg_pkg::PORT_W-1:0] dp_first;
  logic [ftg_pkg::PORT_W-1:0] dp_last;

  logic [ftg_pkg::ADDR_W-1:0] src_adv;
  logic [ftg_pkg::ADDR_W-1:0] dst_adv;
  logic [ftg_pkg::PORT_W-1:0] sport_adv;
  logic [ftg_pkg::PORT_W-1:0] dport_adv;
  logic                       wrap;

  ftg_pkg::excl_wr_t   src_wr;
  ftg_pkg::excl_wr_t   dst_wr;
  ftg_pkg::excl_stat_t src_stat;
  ftg_pkg::excl_stat_t dst_stat;

  logic                        res_emitted;
  logic                        res_last;
  ftg_pkg::status_t            res_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_first   <= '0;
      src_last    <= '0;
      dst_first   <= '0;
      dst_last    <= '0;
      sport_range <= '0;
      dport_range <= '0;
      protocol    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (ftg_pkg::cfg_reg_t'(cfg_index))
        ftg_pkg::REG_SRC_FIRST:   src_first   <= cfg_data;
        ftg_pkg::REG_SRC_LAST:    src_last    <= cfg_data;
        ftg_pkg::REG_DST_FIRST:   dst_first   <= cfg_data;
        ftg_pkg::REG_DST_LAST:    dst_last    <= cfg_data;
        ftg_pkg::REG_SPORT_RANGE: sport_range <= cfg_data;
        ftg_pkg::REG_DPORT_RANGE: dport_range <= cfg_data;
        ftg_pkg::REG_PROTOCOL:    protocol    <= cfg_data[ftg_pkg::PROTO_W-1:0];
        default: ;
      endcase
    end
  end

  assign sp_first = sport_range[31:16];
  assign sp_last  = sport_range[15:0];
  assign dp_first = dport_range[31:16];
  assign dp_last  = dport_range[15:0];

  // the result register frees up when empty or being taken
  assign proc     = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_op   <= ftg_pkg::op_t'(op);
      s1_addr <= entry_addr;
    end
  end

  assign src_wr.en   = proc && (s1_op == ftg_pkg::OP_ADD_SRC);
  assign src_wr.addr = s1_addr;
  assign dst_wr.en   = proc && (s1_op == ftg_pkg::OP_ADD_DST);
  assign dst_wr.addr = s1_addr;

  ftg_excl_table #(.EXCL_DEPTH(EXCL_DEPTH)) u_src_excl (
    .clk         (clk),
    .rst         (rst),
    .wr          (src_wr),
    .lookup_addr (src_cur),
    .stat        (src_stat)
  );

  ftg_excl_table #(.EXCL_DEPTH(EXCL_DEPTH)) u_dst_excl (
    .clk         (clk),
    .rst         (rst),
    .wr          (dst_wr),
    .lookup_addr (dst_cur),
    .stat        (dst_stat)
  );

  // each counter goes back to first on reaching last, else counts up modulo its width
  assign src_adv   = (src_cur == src_last) ? src_first : src_cur + 32'd1;
  assign dst_adv   = (dst_cur == dst_last) ? dst_first : dst_cur + 32'd1;
  assign sport_adv = (sport_cur == sp_last) ? sp_first : sport_cur + 16'd1;
  assign dport_adv = (dport_cur == dp_last) ? dp_first : dport_cur + 16'd1;
  assign wrap = (src_adv == src_first) && (dst_adv == dst_first) &&
                (sport_adv == sp_first) && (dport_adv == dp_first);

  always_comb begin
    src_cur_next   = src_cur;
    dst_cur_next   = dst_cur;
    sport_cur_next = sport_cur;
    dport_cur_next = dport_cur;
    finished_next  = finished;
    res_emitted    = 1'b0;
    res_last       = 1'b0;
    res_status     = ftg_pkg::ST_OK;
    unique case (s1_op)
      ftg_pkg::OP_RESTART: begin
        src_cur_next   = src_first;
        dst_cur_next   = dst_first;
        sport_cur_next = sp_first;
        dport_cur_next = dp_first;
        finished_next  = 1'b0;
      end
      ftg_pkg::OP_ADD_SRC: begin
        if (src_stat.full) begin
          res_status = ftg_pkg::ST_FULL;
        end
      end
      ftg_pkg::OP_ADD_DST: begin
        if (dst_stat.full) begin
          res_status = ftg_pkg::ST_FULL;
        end
      end
      ftg_pkg::OP_STEP: begin
        if (finished) begin
          res_status = ftg_pkg::ST_FINISHED;
        end else begin
          res_emitted    = !src_stat.hit && !dst_stat.hit;
          src_cur_next   = src_adv;
          dst_cur_next   = dst_adv;
          sport_cur_next = sport_adv;
          dport_cur_next = dport_adv;
          finished_next  = wrap;
          res_last       = wrap;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_cur   <= '0;
      dst_cur   <= '0;
      sport_cur <= '0;
      dport_cur <= '0;
      finished  <= 1'b1;
    end else if (proc) begin
      src_cur   <= src_cur_next;
      dst_cur   <= dst_cur_next;
      sport_cur <= sport_cur_next;
      dport_cur <= dport_cur_next;
      finished  <= finished_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // tuple fields read as zero when nothing is emitted
  always_ff @(posedge clk) begin
    if (proc) begin
      emitted   <= res_emitted;
      src_addr  <= res_emitted ? src_cur : '0;
      dst_addr  <= res_emitted ? dst_cur : '0;
      src_port  <= res_emitted ? sport_cur : '0;
      dst_port  <= res_emitted ? dport_cur : '0;
      proto_out <= res_emitted ? protocol : '0;
      last      <= res_last;
      status    <= res_status;
    end
  end

  a_restart_clears_finished: assert property (@(posedge clk) disable iff (rst)
    (proc && s1_op == ftg_pkg::OP_RESTART) |=> !finished)
    else $error("restart did not clear finished");

  a_wrap_sets_finished: assert property (@(posedge clk) disable iff (rst)
    (proc && s1_op == ftg_pkg::OP_STEP && !finished && wrap) |=> (finished && last))
    else $error("period end did not mark finished and last");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input stalled while the pipeline had room");

  a_finished_no_tuple: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ftg_pkg::ST_FINISHED) |-> (!emitted && !last))
    else $error("tuple or last reported after the sequence finished");

endmodule

FILE: test/flow_tuple_checker.sv
`timescale 1ns / 1ps
// checker that tracks the flow tuple sequence and compares every result transaction
module flow_tuple_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [1:0]                     op,
  input  logic [ftg_pkg::ADDR_W-1:0]     entry_addr,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           emitted,
  input  logic [ftg_pkg::ADDR_W-1:0]     src_addr,
  input  logic [ftg_pkg::ADDR_W-1:0]     dst_addr,
  input  logic [ftg_pkg::PORT_W-1:0]     src_port,
  input  logic [ftg_pkg::PORT_W-1:0]     dst_port,
  input  logic [ftg_pkg::PROTO_W-1:0]    proto_out,
  input  logic                           last,
  input  logic [1:0]                     status,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [ftg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ftg_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             outstanding
);

  localparam int DEPTH = ftg_pkg::EXCL_DEPTH_DEF;

  typedef struct packed {
    logic                        emitted;
    logic [ftg_pkg::ADDR_W-1:0]  src_addr;
    logic [ftg_pkg::ADDR_W-1:0]  dst_addr;
    logic [ftg_pkg::PORT_W-1:0]  src_port;
    logic [ftg_pkg::PORT_W-1:0]  dst_port;
    logic [ftg_pkg::PROTO_W-1:0] proto;
    logic                        last;
    ftg_pkg::status_t            status;
  } tuple_t;

  logic [31:0] src_first_q, src_last_q, dst_first_q, dst_last_q;
  logic [31:0] sport_rng_q, dport_rng_q;
  logic [7:0]  proto_q;

  logic [31:0] src_pos, dst_pos;
  logic [15:0] sport_pos, dport_pos;
  logic        seq_done;
  logic [31:0] src_block [DEPTH];
  logic [31:0] dst_block [DEPTH];
  int          src_used, dst_used;

  tuple_t tuple_q[$];
  tuple_t got, want;
  int     errs = 0;

  // counter goes back to first when it sits on last, otherwise counts up and wraps
  function automatic logic [31:0] wrap_step(input logic [31:0] cur, input logic [31:0] first,
                                            input logic [31:0] last_v, input logic [31:0] mask);
    if (cur == last_v) return first;
    return (cur + 32'd1) & mask;
  endfunction

  function automatic tuple_t tuple_for(input ftg_pkg::op_t cmd, input logic [31:0] addr);
    tuple_t      r;
    logic        blocked;
    logic [15:0] sp_first, sp_last, dp_first, dp_last;
    logic [31:0] nxt;
    int          i;
    r = '0;
    r.status = ftg_pkg::ST_OK;
    sp_first = sport_rng_q[31:16];
    sp_last  = sport_rng_q[15:0];
    dp_first = dport_rng_q[31:16];
    dp_last  = dport_rng_q[15:0];
    case (cmd)
      ftg_pkg::OP_RESTART: begin
        src_pos   = src_first_q;
        dst_pos   = dst_first_q;
        sport_pos = sp_first;
        dport_pos = dp_first;
        seq_done  = 1'b0;
      end
      ftg_pkg::OP_ADD_SRC: begin
        if (src_used >= DEPTH) begin
          r.status = ftg_pkg::ST_FULL;
        end else begin
          src_block[src_used] = addr;
          src_used++;
        end
      end
      ftg_pkg::OP_ADD_DST: begin
        if (dst_used >= DEPTH) begin
          r.status = ftg_pkg::ST_FULL;
        end else begin
          dst_block[dst_used] = addr;
          dst_used++;
        end
      end
      default: begin
        if (seq_done) begin
          r.status = ftg_pkg::ST_FINISHED;
        end else begin
          blocked = 1'b0;
          for (i = 0; i < src_used; i++)
            if (src_block[i] == src_pos) blocked = 1'b1;
          for (i = 0; i < dst_used; i++)
            if (dst_block[i] == dst_pos) blocked = 1'b1;
          if (!blocked) begin
            r.emitted  = 1'b1;
            r.src_addr = src_pos;
            r.dst_addr = dst_pos;
            r.src_port = sport_pos;
            r.dst_port = dport_pos;
            r.proto    = proto_q;
          end
          src_pos = wrap_step(src_pos, src_first_q, src_last_q, 32'hFFFF_FFFF);
          dst_pos = wrap_step(dst_pos, dst_first_q, dst_last_q, 32'hFFFF_FFFF);
          nxt = wrap_step({16'h0, sport_pos}, {16'h0, sp_first}, {16'h0, sp_last}, 32'h0000_FFFF);
          sport_pos = nxt[15:0];
          nxt = wrap_step({16'h0, dport_pos}, {16'h0, dp_first}, {16'h0, dp_last}, 32'h0000_FFFF);
          dport_pos = nxt[15:0];
          if (src_pos == src_first_q && dst_pos == dst_first_q &&
              sport_pos == sp_first && dport_pos == dp_first) begin
            seq_done = 1'b1;
            r.last = 1'b1;
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic flag(input string field, input logic [31:0] w, input logic [31:0] g);
    $error("%s mismatch: expected %0h, got %0h", field, w, g);
    errs++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      src_first_q = '0; src_last_q = '0; dst_first_q = '0; dst_last_q = '0;
      sport_rng_q = '0; dport_rng_q = '0; proto_q = '0;
      src_pos = '0; dst_pos = '0; sport_pos = '0; dport_pos = '0;
      seq_done = 1'b1;
      src_used = 0;
      dst_used = 0;
      tuple_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = '{emitted, src_addr, dst_addr, src_port, dst_port, proto_out, last,
                ftg_pkg::status_t'(status)};
        if (tuple_q.size() == 0) begin
          $error("result transaction with no command outstanding");
          errs++;
        end else begin
          want = tuple_q.pop_front();
          if (got.emitted !== want.emitted)
            flag("emitted", 32'(want.emitted), 32'(got.emitted));
          if (got.src_addr !== want.src_addr) flag("src_addr", want.src_addr, got.src_addr);
          if (got.dst_addr !== want.dst_addr) flag("dst_addr", want.dst_addr, got.dst_addr);
          if (got.src_port !== want.src_port)
            flag("src_port", 32'(want.src_port), 32'(got.src_port));
          if (got.dst_port !== want.dst_port)
            flag("dst_port", 32'(want.dst_port), 32'(got.dst_port));
          if (got.proto !== want.proto)
            flag("proto_out", 32'(want.proto), 32'(got.proto));
          if (got.last !== want.last) flag("last", 32'(want.last), 32'(got.last));
          if (got.status !== want.status)
            flag("status", 32'(want.status), 32'(got.status));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (ftg_pkg::cfg_reg_t'(cfg_index))
          ftg_pkg::REG_SRC_FIRST:   src_first_q = cfg_data;
          ftg_pkg::REG_SRC_LAST:    src_last_q  = cfg_data;
          ftg_pkg::REG_DST_FIRST:   dst_first_q = cfg_data;
          ftg_pkg::REG_DST_LAST:    dst_last_q  = cfg_data;
          ftg_pkg::REG_SPORT_RANGE: sport_rng_q = cfg_data;
          ftg_pkg::REG_DPORT_RANGE: dport_rng_q = cfg_data;
          ftg_pkg::REG_PROTOCOL:    proto_q     = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        tuple_q.push_back(tuple_for(ftg_pkg::op_t'(op), entry_addr));
    end
    fail_count  <= errs;
    outstanding <= tuple_q.size();
  end

endmodule

FILE: test/flow_tuple_generator_core_tb.sv
`timescale 1ns / 1ps
// testbench top for the flow tuple generator: stimulus, flow control and verdict
module flow_tuple_generator_core_tb;

  localparam int          ITEMS       = 1420;
  localparam int          LIMIT       = 500000;
  localparam int          HOLD_CYCLES = 300;
  localparam logic [31:0] SRC_BASE    = 32'h0A00_0000;
  localparam logic [31:0] DST_BASE    = 32'hC0A8_0000;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  ftg_pkg::op_t                   cmd_op = ftg_pkg::OP_STEP;
  logic [ftg_pkg::ADDR_W-1:0]     entry_addr = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic                           emitted;
  logic [ftg_pkg::ADDR_W-1:0]     src_addr, dst_addr;
  logic [ftg_pkg::PORT_W-1:0]     src_port, dst_port;
  logic [ftg_pkg::PROTO_W-1:0]    proto_out;
  logic                           last;
  logic [1:0]                     status;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  ftg_pkg::cfg_reg_t              cfg_index = ftg_pkg::REG_SRC_FIRST;
  logic [ftg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count, outstanding;
  int issued = 0;
  int cycles = 0;
  bit tx_gaps = 1'b0;
  bit rx_stalls = 1'b0;
  bit quiet = 1'b0;
  bit held = 1'b0;

  flow_tuple_generator_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .op(cmd_op), .entry_addr(entry_addr),
    .out_valid(out_valid), .out_ready(out_ready), .emitted(emitted),
    .src_addr(src_addr), .dst_addr(dst_addr), .src_port(src_port), .dst_port(dst_port),
    .proto_out(proto_out), .last(last), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  flow_tuple_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .op(cmd_op), .entry_addr(entry_addr),
    .out_valid(out_valid), .out_ready(out_ready), .emitted(emitted),
    .src_addr(src_addr), .dst_addr(dst_addr), .src_port(src_port), .dst_port(dst_port),
    .proto_out(proto_out), .last(last), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // mostly addresses near the configured ranges so exclusions actually hit
  function automatic logic [31:0] excl_addr(input logic [31:0] base);
    if ($urandom_range(0, 4) == 0) return $urandom;
    return base + $urandom_range(0, 63);
  endfunction

  task automatic issue(input ftg_pkg::op_t c, input logic [31:0] a);
    if (tx_gaps && !quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd_op     <= c;
    entry_addr <= a;
    do @(posedge clk); while (!in_ready);
    issued++;
    if (issued >= ITEMS - 150) quiet = 1'b1;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input ftg_pkg::cfg_reg_t idx, input logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // receiver: one long hold-off while commands keep coming, otherwise short stalls
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (!held && issued >= 300 && in_valid) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rx_stalls && !quiet && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    int          ph, kind, n, r, i, rs_pct;
    logic [31:0] vals [7];
    logic [31:0] a;
    logic [15:0] pf;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // registers still at reset: finished until restart, then a one-step period
    issue(ftg_pkg::OP_STEP, 32'hFFFF_FFFF);
    issue(ftg_pkg::OP_RESTART, 32'h0);
    issue(ftg_pkg::OP_STEP, 32'h5555_AAAA);
    issue(ftg_pkg::OP_STEP, 32'hAAAA_5555);
    drain();

    // wrapping ranges at the top of both counter widths, period of 12
    write_reg(ftg_pkg::REG_SRC_FIRST, 32'hFFFF_FFFE);
    write_reg(ftg_pkg::REG_SRC_LAST, 32'h0000_0001);
    write_reg(ftg_pkg::REG_DST_FIRST, 32'h0000_0000);
    write_reg(ftg_pkg::REG_DST_LAST, 32'h0000_0002);
    write_reg(ftg_pkg::REG_SPORT_RANGE, {16'hFFFF, 16'h0000});
    write_reg(ftg_pkg::REG_DPORT_RANGE, {16'h0005, 16'h0005});
    write_reg(ftg_pkg::REG_PROTOCOL, 32'h0000_00FF);
    cfg_valid <= 1'b0;
    issue(ftg_pkg::OP_ADD_SRC, 32'hFFFF_FFFF);
    issue(ftg_pkg::OP_ADD_DST, 32'h0000_0000);
    issue(ftg_pkg::OP_RESTART, 32'h0);
    for (i = 0; i < 13; i++) issue(ftg_pkg::OP_STEP, $urandom);

    ph = 0;
    while (issued < ITEMS) begin
      drain();
      case (ph)
        0, 1, 3: kind = 0;
        2:       kind = 2;
        4:       kind = 3;
        5:       kind = 1;
        6:       kind = 4;
        default: kind = ($urandom_range(0, 99) < 85) ? 0 : $urandom_range(1, 4);
      endcase
      case (kind)
        0: begin
          a = SRC_BASE + $urandom_range(0, 60);
          vals[ftg_pkg::REG_SRC_FIRST] = a;
          vals[ftg_pkg::REG_SRC_LAST]  = a + $urandom_range(0, 3);
          a = DST_BASE + $urandom_range(0, 60);
          vals[ftg_pkg::REG_DST_FIRST] = a;
          vals[ftg_pkg::REG_DST_LAST]  = a + $urandom_range(0, 3);
          pf = 16'($urandom);
          vals[ftg_pkg::REG_SPORT_RANGE] = {pf, pf + 16'($urandom_range(0, 3))};
          pf = 16'($urandom);
          vals[ftg_pkg::REG_DPORT_RANGE] = {pf, pf + 16'($urandom_range(0, 3))};
        end
        1: begin
          // last one below first: every value of the counter is visited
          a = $urandom;
          vals[ftg_pkg::REG_SRC_FIRST] = a;
          vals[ftg_pkg::REG_SRC_LAST]  = a - 32'd1;
          a = $urandom;
          vals[ftg_pkg::REG_DST_FIRST] = a;
          vals[ftg_pkg::REG_DST_LAST]  = a - 32'd1;
          pf = 16'($urandom);
          vals[ftg_pkg::REG_SPORT_RANGE] = {pf, pf - 16'd1};
          pf = 16'($urandom);
          vals[ftg_pkg::REG_DPORT_RANGE] = {pf, pf - 16'd1};
        end
        2: for (i = 0; i < 6; i++) vals[i] = 32'hFFFF_FFFF;
        3: for (i = 0; i < 6; i++) vals[i] = 32'h0;
        default: for (i = 0; i < 6; i++) vals[i] = $urandom;
      endcase
      if (kind == 2) vals[ftg_pkg::REG_PROTOCOL] = 32'hFF;
      else if (kind == 3) vals[ftg_pkg::REG_PROTOCOL] = 32'h0;
      else vals[ftg_pkg::REG_PROTOCOL] = $urandom_range(0, 255);

      // partial updates leave the running sequence under new registers
      for (i = 0; i < 7; i++)
        if (ph == 0 || $urandom_range(0, 3) != 0) write_reg(ftg_pkg::cfg_reg_t'(i), vals[i]);
      cfg_valid <= 1'b0;

      tx_gaps   = ($urandom_range(0, 2) != 0);
      rx_stalls = ($urandom_range(0, 2) != 0);
      rs_pct    = (kind == 0) ? 4 : 15;
      if ($urandom_range(0, 4) != 0) issue(ftg_pkg::OP_RESTART, $urandom);
      n = $urandom_range(30, 110);
      for (i = 0; i < n && issued < ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < rs_pct) issue(ftg_pkg::OP_RESTART, $urandom);
        else if (r < rs_pct + 7) issue(ftg_pkg::OP_ADD_SRC, excl_addr(SRC_BASE));
        else if (r < rs_pct + 14) issue(ftg_pkg::OP_ADD_DST, excl_addr(DST_BASE));
        else issue(ftg_pkg::OP_STEP, $urandom);
      end
      ph++;
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/ftg_pkg.sv
rtl/ftg_excl_table.sv
rtl/flow_tuple_generator_core.sv
test/flow_tuple_checker.sv
test/flow_tuple_generator_core_tb.sv
